// File: sv/assert_macros.svh
// Assertion shorthands for the event program sequencer.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define EPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event sequencer check failed");

`endif

// File: sv/eps_pkg.sv
// Shared types and codes of the event program sequencer.
// No dependencies; eps_prog_store, the sequencer and its bench import it.
`default_nettype none

package eps_pkg;

	localparam int EV_W = 11;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STEP  = 2'd2;
	localparam logic [1:0] FUNC_ABORT = 2'd3;

	localparam logic [3:0] KIND_CONTINUE = 4'd0;
	localparam logic [3:0] KIND_SUBSTART = 4'd1;
	localparam logic [3:0] KIND_WAIT     = 4'd2;
	localparam logic [3:0] KIND_WAIT_MAX = 4'd3;
	localparam logic [3:0] KIND_LOOP     = 4'd4;
	localparam logic [3:0] KIND_END_LOOP = 4'd5;
	localparam logic [3:0] KIND_CALL     = 4'd6;
	localparam logic [3:0] KIND_RETURN   = 4'd7;
	localparam logic [3:0] KIND_EXIT     = 4'd8;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_UNKNOWN   = 3'd1;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
	localparam logic [2:0] STATUS_LOOP_EMPTY = 3'd3;
	localparam logic [2:0] STATUS_BAD_TARGET = 3'd4;
	localparam logic [2:0] STATUS_RET_EMPTY = 3'd5;

	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] argument;
		logic        gradient;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} prog_entry_t;

	// Loop entries use both fields; return entries use start only.
	typedef struct packed {
		logic [23:0]     count;
		logic [EV_W-1:0] start;
	} stack_entry_t;

endpackage

`default_nettype wire

// File: sv/eps_prog_store.sv
// Program store: one write port, one registered read port.
// Depends on eps_pkg for the entry layout.
`default_nettype none

module eps_prog_store
	import eps_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire prog_entry_t              wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output prog_entry_t                   rdata
);

	prog_entry_t mem [DEPTH];
	prog_entry_t rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

`default_nettype wire

// File: sv/event_program_sequencer.sv
// Channel   Signals                                   Handshake
// command   func entry_index op_kind op_argument ...  start high, busy low
// config    cfg_wdata (program_length)                cfg_we high
// result    emitted x/y/z_out event_executed ...      strobe, one cycle
//
// A step that executes an event: the accept edge registers the program
// entry and both stack tops and enters ST_EXEC; the ST_EXEC edge writes back
// and loads the result registers, which drive the result ports.
// busy is high while in ST_EXEC.
// Write, start, abort and a step while finished all act at the accept edge.
// No clearing pass after reset: program and stacks are valid once written.
// The receiver cannot stall; each result stands for exactly one cycle.
// Depends on eps_pkg, eps_prog_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module event_program_sequencer
	import eps_pkg::*;
#(
	parameter int PROGRAM_DEPTH = 1024,
	parameter int STACK_DEPTH   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [9:0]  entry_index,
	input  wire logic [3:0]  op_kind,
	input  wire logic [23:0] op_argument,
	input  wire logic        has_gradient,
	input  wire logic [15:0] x_word,
	input  wire logic [15:0] y_word,
	input  wire logic [15:0] z_word,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	output logic             strobe,
	output logic             emitted,
	output logic [15:0]      x_out,
	output logic [15:0]      y_out,
	output logic [15:0]      z_out,
	output logic [9:0]       event_executed,
	output logic             finished,
	output logic [2:0]       status
);

	localparam int AW = $clog2(PROGRAM_DEPTH);
	localparam int SI = $clog2(STACK_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam logic [SW-1:0] SD_FULL = SW'(STACK_DEPTH);
	localparam logic SEL_LOOP = 1'b0;
	localparam logic SEL_RET  = 1'b1;

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t          state_q;
	logic [EV_W-1:0] cur_q;
	logic [SW-1:0]   ldep_q;
	logic [SW-1:0]   rdep_q;
	logic            done_q;
	logic [10:0]     plen_q;

	logic        strobe_q;
	logic        emitted_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [15:0] z_q;
	logic [9:0]  event_q;
	logic        fin_q;
	logic [2:0]  status_q;

	logic        accept;
	logic [10:0] len;
	logic        step_fetch;
	logic        prog_we;
	prog_entry_t prog_wdata;
	prog_entry_t entry;

	stack_entry_t stk_mem [2**(SI+1)];
	stack_entry_t ltop_s1;
	stack_entry_t rtop_s1;
	logic [SW-1:0] ldep_m1;
	logic [SW-1:0] rdep_m1;

	// execute stage results
	logic [EV_W-1:0] next_ev;
	logic [2:0]      st_n;
	logic [SW-1:0]   ldep_n;
	logic [SW-1:0]   rdep_n;
	logic            done_n;
	logic            stk_we;
	logic [SI:0]     stk_waddr;
	stack_entry_t    stk_wdata;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;

	always_comb begin
		if (32'(plen_q) < 32'(PROGRAM_DEPTH)) begin
			len = plen_q;
		end else begin
			len = 11'(PROGRAM_DEPTH);
		end
	end

	assign step_fetch = accept && (func == FUNC_STEP) && !done_q && (cur_q < len);
	assign prog_we    = accept && (func == FUNC_WRITE)
		&& (32'(entry_index) < 32'(PROGRAM_DEPTH));

	always_comb begin
		prog_wdata.kind     = op_kind;
		prog_wdata.argument = op_argument;
		prog_wdata.gradient = has_gradient;
		prog_wdata.x        = x_word;
		prog_wdata.y        = y_word;
		prog_wdata.z        = z_word;
	end

	eps_prog_store #(
		.DEPTH(PROGRAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (prog_we),
		.waddr(AW'(entry_index)),
		.wdata(prog_wdata),
		.re   (step_fetch),
		.raddr(AW'(cur_q)),
		.rdata(entry)
	);

	assign ldep_m1 = ldep_q - SW'(1);
	assign rdep_m1 = rdep_q - SW'(1);

	// Stack memory: loop stack in the lower half, return stack in the upper.
	always_ff @(posedge clk) begin
		if (stk_we && state_q == ST_EXEC) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (step_fetch) begin
			ltop_s1 <= stk_mem[{SEL_LOOP, ldep_m1[SI-1:0]}];
			rtop_s1 <= stk_mem[{SEL_RET, rdep_m1[SI-1:0]}];
		end
	end

	always_comb begin
		next_ev   = cur_q + EV_W'(1);
		st_n      = STATUS_OK;
		ldep_n    = ldep_q;
		rdep_n    = rdep_q;
		stk_we    = 1'b0;
		stk_waddr = {SEL_LOOP, ldep_q[SI-1:0]};
		stk_wdata = '{count: entry.argument, start: cur_q};
		case (entry.kind)
			KIND_CONTINUE, KIND_SUBSTART, KIND_WAIT, KIND_WAIT_MAX: begin
			end
			KIND_LOOP: begin
				// hold a live loop: its counter is still running
				if (!(ldep_q != '0 && ltop_s1.start == cur_q && ltop_s1.count != '0)) begin
					if (ldep_q == SD_FULL) begin
						st_n = STATUS_OVERFLOW;
					end else begin
						stk_we = 1'b1;
						ldep_n = ldep_q + SW'(1);
					end
				end
			end
			KIND_END_LOOP: begin
				if (ldep_q == '0) begin
					st_n = STATUS_LOOP_EMPTY;
				end else if (ltop_s1.count <= 24'd1) begin
					ldep_n = ldep_m1;
				end else begin
					stk_we    = 1'b1;
					stk_waddr = {SEL_LOOP, ldep_m1[SI-1:0]};
					stk_wdata = '{count: ltop_s1.count - 24'd1, start: ltop_s1.start};
					next_ev   = ltop_s1.start;
				end
			end
			KIND_CALL: begin
				if (entry.argument > 24'(len)) begin
					st_n    = STATUS_BAD_TARGET;
					next_ev = len;
				end else begin
					if (rdep_q == SD_FULL) begin
						st_n = STATUS_OVERFLOW;
					end else begin
						stk_we    = 1'b1;
						stk_waddr = {SEL_RET, rdep_q[SI-1:0]};
						stk_wdata = '{count: 24'd0, start: cur_q + EV_W'(1)};
						rdep_n    = rdep_q + SW'(1);
					end
					next_ev = entry.argument[EV_W-1:0];
				end
			end
			KIND_RETURN: begin
				if (rdep_q == '0) begin
					st_n = STATUS_RET_EMPTY;
				end else begin
					rdep_n  = rdep_m1;
					next_ev = rtop_s1.start;
					if (rtop_s1.start > len) begin
						st_n    = STATUS_BAD_TARGET;
						next_ev = len;
					end
				end
			end
			KIND_EXIT: begin
				next_ev = len;
			end
			default: begin
				st_n = STATUS_UNKNOWN;
			end
		endcase
		done_n = (entry.kind == KIND_EXIT) || (next_ev >= len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			ldep_q    <= '0;
			rdep_q    <= '0;
			done_q    <= 1'b1;
			plen_q    <= '0;
			strobe_q  <= 1'b0;
			emitted_q <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			event_q   <= '0;
			fin_q     <= 1'b0;
			status_q  <= STATUS_OK;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				plen_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_START: begin
								cur_q  <= '0;
								ldep_q <= '0;
								rdep_q <= '0;
								done_q <= 1'b0;
							end
							FUNC_ABORT: begin
								done_q <= 1'b1;
							end
							FUNC_STEP: begin
								if (done_q || cur_q >= len) begin
									// nothing to run: report finished
									done_q    <= 1'b1;
									strobe_q  <= 1'b1;
									emitted_q <= 1'b0;
									x_q       <= '0;
									y_q       <= '0;
									z_q       <= '0;
									event_q   <= cur_q[9:0];
									fin_q     <= 1'b1;
									status_q  <= STATUS_OK;
								end else begin
									state_q <= ST_EXEC;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EXEC: begin
					cur_q     <= next_ev;
					ldep_q    <= ldep_n;
					rdep_q    <= rdep_n;
					done_q    <= done_n;
					strobe_q  <= 1'b1;
					emitted_q <= entry.gradient;
					x_q       <= entry.gradient ? entry.x : 16'd0;
					y_q       <= entry.gradient ? entry.y : 16'd0;
					z_q       <= entry.gradient ? entry.z : 16'd0;
					event_q   <= cur_q[9:0];
					fin_q     <= done_n;
					status_q  <= st_n;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign emitted        = emitted_q;
	assign x_out          = x_q;
	assign y_out          = y_q;
	assign z_out          = z_q;
	assign event_executed = event_q;
	assign finished       = fin_q;
	assign status         = status_q;

	`EPS_ASSERT_NEXT(a_exec_one_cycle, busy, !busy && strobe)
	`EPS_ASSERT_SAME(a_loop_depth_bound, 1'b1, ldep_q <= SD_FULL)
	`EPS_ASSERT_SAME(a_ret_depth_bound, 1'b1, rdep_q <= SD_FULL)
	`EPS_ASSERT_SAME(a_bad_target_ends, strobe && status == STATUS_BAD_TARGET, finished)
	`EPS_ASSERT_SAME(a_no_emit_when_idle_step, strobe && !emitted, x_out == 16'd0)

endmodule

`default_nettype wire

// File: dv/event_program_sequencer_tb.sv
// Self-checking testbench for event_program_sequencer: directed rows, then random programs.
// A predictor in this file computes every step report; uses eps_pkg and the sequencer RTL.
`default_nettype none

module event_program_sequencer_tb;
	import eps_pkg::*;

	localparam int PROG_DEPTH = 1024;
	localparam int STACK_DEPTH = 32;
	localparam int ITEM_TARGET = 1400;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [3:0] KIND_UNKNOWN_TOP = 4'd15;
	localparam int SCEN_STRUCTURED = 0;
	localparam int SCEN_RANDOM = 1;
	localparam int SCEN_STACK_FILL = 2;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  index;
		logic [3:0]  kind;
		logic [23:0] arg;
		logic        grad;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} cmd_t;

	typedef struct packed {
		logic        emitted;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [9:0]  ev;
		logic        fin;
		logic [2:0]  status;
	} report_t;

	typedef struct {
		bit          is_cfg;
		logic [10:0] cfg_val;
		cmd_t        cmd;
		bit          typed;
		report_t     want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] func;
	logic [9:0] entry_index;
	logic [3:0] op_kind;
	logic [23:0] op_argument;
	logic has_gradient;
	logic [15:0] x_word;
	logic [15:0] y_word;
	logic [15:0] z_word;
	logic cfg_we;
	logic [10:0] cfg_wdata;
	logic strobe;
	logic emitted;
	logic [15:0] x_out;
	logic [15:0] y_out;
	logic [15:0] z_out;
	logic [9:0] event_executed;
	logic finished;
	logic [2:0] status;

	event_program_sequencer #(
		.PROGRAM_DEPTH(PROG_DEPTH),
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.entry_index(entry_index),
		.op_kind(op_kind),
		.op_argument(op_argument),
		.has_gradient(has_gradient),
		.x_word(x_word),
		.y_word(y_word),
		.z_word(z_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.emitted(emitted),
		.x_out(x_out),
		.y_out(y_out),
		.z_out(z_out),
		.event_executed(event_executed),
		.finished(finished),
		.status(status)
	);

	// sequencer state as the predictor sees it
	prog_entry_t program_mem [PROG_DEPTH];
	bit written [PROG_DEPTH];
	int unsigned loop_starts [STACK_DEPTH];
	int unsigned loop_counts [STACK_DEPTH];
	int unsigned return_addrs [STACK_DEPTH];
	int unsigned pred_event = 0;
	int unsigned loop_depth = 0;
	int unsigned return_depth = 0;
	bit seq_done = 1'b1;
	int unsigned prog_length = 0;

	report_t step_reports_due [$];
	bit typed_valid = 1'b0;
	report_t typed_value;

	int unsigned items_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned gradient_reports = 0;
	int unsigned finished_reports = 0;
	int unsigned status_seen [8];
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned idle_pct = 33;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned effective_length();
		return (prog_length < PROG_DEPTH) ? prog_length : PROG_DEPTH;
	endfunction

	task automatic advance_sequencer(input cmd_t c, output report_t r);
		int unsigned len;
		int unsigned cur;
		int unsigned nxt;
		logic [2:0] st;
		prog_entry_t e;
		len = effective_length();
		r = '0;
		case (c.func)
			FUNC_WRITE: begin
				program_mem[c.index] = '{c.kind, c.arg, c.grad, c.x, c.y, c.z};
				written[c.index] = 1'b1;
			end
			FUNC_START: begin
				pred_event = 0;
				loop_depth = 0;
				return_depth = 0;
				seq_done = 1'b0;
			end
			FUNC_ABORT: seq_done = 1'b1;
			default: begin
				if (seq_done || pred_event >= len) begin
					// nothing runs: report where the sequencer stands
					seq_done = 1'b1;
					r.ev = 10'(pred_event);
					r.fin = 1'b1;
				end else begin
					cur = pred_event;
					e = program_mem[cur];
					nxt = cur + 1;
					st = STATUS_OK;
					case (e.kind)
						KIND_CONTINUE, KIND_SUBSTART, KIND_WAIT, KIND_WAIT_MAX: ;
						KIND_LOOP: begin
							// a loop whose counter is still live is not pushed again
							if (!(loop_depth > 0 && loop_starts[loop_depth - 1] == cur &&
									loop_counts[loop_depth - 1] > 0)) begin
								if (loop_depth >= STACK_DEPTH) begin
									st = STATUS_OVERFLOW;
								end else begin
									loop_counts[loop_depth] = e.argument;
									loop_starts[loop_depth] = cur;
									loop_depth++;
								end
							end
						end
						KIND_END_LOOP: begin
							if (loop_depth == 0) begin
								st = STATUS_LOOP_EMPTY;
							end else if (loop_counts[loop_depth - 1] <= 1) begin
								loop_counts[loop_depth - 1] = 0;
								loop_depth--;
							end else begin
								loop_counts[loop_depth - 1]--;
								nxt = loop_starts[loop_depth - 1];
							end
						end
						KIND_CALL: begin
							if (e.argument > len) begin
								st = STATUS_BAD_TARGET;
								nxt = len;
							end else begin
								// a full stack drops the return address but still jumps
								if (return_depth >= STACK_DEPTH) begin
									st = STATUS_OVERFLOW;
								end else begin
									return_addrs[return_depth] = cur + 1;
									return_depth++;
								end
								nxt = e.argument;
							end
						end
						KIND_RETURN: begin
							if (return_depth == 0) begin
								st = STATUS_RET_EMPTY;
							end else begin
								return_depth--;
								nxt = return_addrs[return_depth];
								if (nxt > len) begin
									st = STATUS_BAD_TARGET;
									nxt = len;
								end
							end
						end
						KIND_EXIT: nxt = len;
						default: st = STATUS_UNKNOWN;
					endcase
					pred_event = nxt;
					if (e.kind == KIND_EXIT || nxt >= len)
						seq_done = 1'b1;
					r.emitted = e.gradient;
					if (e.gradient) begin
						r.x = e.x;
						r.y = e.y;
						r.z = e.z;
					end
					r.ev = 10'(cur);
					r.fin = seq_done;
					r.status = st;
				end
			end
		endcase
	endtask

	// accept items and config writes, check step reports
	always @(posedge clk) begin : watch
		cmd_t seen;
		report_t got;
		report_t want;
		report_t predicted;
		bit active;
		if (arst_n) begin
			active = 1'b0;
			if (cfg_we) begin
				prog_length = cfg_wdata;
				active = 1'b1;
			end
			if (start && !busy) begin
				seen = {func, entry_index, op_kind, op_argument, has_gradient,
					x_word, y_word, z_word};
				advance_sequencer(seen, predicted);
				if (seen.func == FUNC_STEP)
					step_reports_due.push_back(typed_valid ? typed_value : predicted);
				items_accepted++;
				active = 1'b1;
			end
			if (strobe) begin
				got = {emitted, x_out, y_out, z_out, event_executed, finished, status};
				active = 1'b1;
				if (step_reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("step report with none outstanding: event %0d status %0d",
							got.ev, got.status);
				end else begin
					want = step_reports_due.pop_front();
					reports_checked++;
					if (got.emitted) gradient_reports++;
					if (got.fin) finished_reports++;
					status_seen[got.status]++;
					if (got.emitted !== want.emitted || got.x !== want.x ||
							got.y !== want.y || got.z !== want.z || got.ev !== want.ev ||
							got.fin !== want.fin || got.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"report %0d mismatch: got emitted=%b x=%h y=%h z=%h",
								" event=%0d finished=%b status=%0d; want emitted=%b",
								" x=%h y=%h z=%h event=%0d finished=%b status=%0d"},
								reports_checked, got.emitted, got.x, got.y, got.z, got.ev,
								got.fin, got.status, want.emitted, want.x, want.y, want.z,
								want.ev, want.fin, want.status);
					end
				end
			end
			stall_cycles = active ? 0 : stall_cycles + 1;
		end
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("event_program_sequencer test failed");
		$finish;
	end

	function automatic cmd_t entry_cmd(input logic [9:0] idx, input logic [3:0] kind,
			input logic [23:0] arg);
		cmd_t c;
		c.func = FUNC_WRITE;
		c.index = idx;
		c.kind = kind;
		c.arg = arg;
		c.grad = 1'($urandom);
		c.x = 16'($urandom);
		c.y = 16'($urandom);
		c.z = 16'($urandom);
		return c;
	endfunction

	function automatic cmd_t control_cmd(input logic [1:0] f);
		cmd_t c;
		c = entry_cmd(10'($urandom), 4'($urandom), 24'($urandom));
		c.func = f;
		return c;
	endfunction

	function automatic cmd_t random_entry(input logic [9:0] idx, input int unsigned len);
		int unsigned pick;
		logic [3:0] kind;
		logic [23:0] arg;
		pick = $urandom_range(99);
		arg = 24'($urandom);
		if (pick < 40) begin
			kind = 4'($urandom_range(KIND_CONTINUE, KIND_WAIT_MAX));
		end else if (pick < 55) begin
			kind = KIND_LOOP;
			if ($urandom_range(99) < 85) arg = 24'($urandom_range(0, 3));
		end else if (pick < 68) begin
			kind = KIND_END_LOOP;
		end else if (pick < 78) begin
			kind = KIND_CALL;
			if ($urandom_range(99) < 80) arg = 24'($urandom_range(0, len));
		end else if (pick < 88) begin
			kind = KIND_RETURN;
		end else if (pick < 93) begin
			kind = KIND_EXIT;
		end else begin
			kind = 4'($urandom_range(KIND_EXIT + 1, KIND_UNKNOWN_TOP));
		end
		return entry_cmd(idx, kind, arg);
	endfunction

	// all driver tasks are entered and left at a falling edge
	task automatic send_item(input cmd_t c);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = c.func;
		entry_index = c.index;
		op_kind = c.kind;
		op_argument = c.arg;
		has_gradient = c.grad;
		x_word = c.x;
		y_word = c.y;
		z_word = c.z;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_step();
		// fill the entry about to run if it was never loaded
		if (!seq_done && pred_event < effective_length() && !written[pred_event])
			send_item(random_entry(10'(pred_event), effective_length()));
		send_item(control_cmd(FUNC_STEP));
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (step_reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [10:0] len);
		cfg_we = 1'b1;
		cfg_wdata = len;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_scenario(input int flavor);
		int unsigned len;
		int unsigned reps;
		int unsigned pick;
		int unsigned i;
		case (flavor)
			SCEN_STRUCTURED: begin
				len = $urandom_range(7, 24);
				reps = $urandom_range(20, 90);
			end
			SCEN_STACK_FILL: begin
				len = $urandom_range(2, 24);
				reps = $urandom_range(66, 76);
			end
			default: begin
				pick = $urandom_range(99);
				if (pick < 10) len = 0;
				else if (pick < 20) len = PROG_DEPTH;
				else if (pick < 30) len = $urandom_range(25, PROG_DEPTH - 1);
				else len = $urandom_range(1, 24);
				reps = $urandom_range(5, 60);
			end
		endcase
		drain_results();
		write_length(11'(len));
		if (flavor == SCEN_STACK_FILL) begin
			// a zero-count loop re-pushes on each call back to it: both stacks fill
			send_item(entry_cmd(10'd0, KIND_LOOP, 24'd0));
			send_item(entry_cmd(10'd1, KIND_CALL, 24'd0));
		end else if (flavor == SCEN_STRUCTURED) begin
			send_item(entry_cmd(10'd0, KIND_LOOP, 24'($urandom_range(0, 3))));
			send_item(entry_cmd(10'd1, KIND_LOOP, 24'($urandom_range(0, 3))));
			send_item(entry_cmd(10'd2, KIND_CALL, 24'(len - 2)));
			send_item(entry_cmd(10'd3, KIND_END_LOOP, 24'($urandom)));
			send_item(entry_cmd(10'd4, KIND_END_LOOP, 24'($urandom)));
			for (i = 5; i < len - 2; i++)
				send_item(random_entry(10'(i), len));
			send_item(entry_cmd(10'(len - 2),
				4'($urandom_range(KIND_CONTINUE, KIND_WAIT_MAX)), 24'($urandom)));
			send_item(entry_cmd(10'(len - 1), KIND_RETURN, 24'($urandom)));
		end else begin
			for (i = 0; i < len && i < 16; i++)
				send_item(random_entry(10'(i), len));
		end
		send_item(control_cmd(FUNC_START));
		repeat (reps) begin
			pick = $urandom_range(99);
			if (pick < 4) send_item(random_entry(10'($urandom_range(0, PROG_DEPTH - 1)), len));
			else if (pick < 6) send_item(control_cmd(FUNC_ABORT));
			else if (pick < 8) send_item(control_cmd(FUNC_START));
			else if (pick < 12) drain_results();
			else send_step();
		end
	endtask

	function automatic row_t cfg_row(input logic [10:0] v);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic row_t cmd_row(input logic [1:0] f, input logic [9:0] idx,
			input logic [3:0] kind, input logic [23:0] arg, input logic grad,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		row_t r;
		r = '{default: '0};
		r.cmd = '{f, idx, kind, arg, grad, x, y, z};
		return r;
	endfunction

	function automatic row_t step_row(input logic emit, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input logic [9:0] ev,
			input logic fin, input logic [2:0] st);
		row_t r;
		r = cmd_row(FUNC_STEP, '0, '0, '0, 1'b0, '0, '0, '0);
		r.typed = 1'b1;
		r.want = '{emit, x, y, z, ev, fin, st};
		return r;
	endfunction

	initial begin : stimulus
		row_t rows [$];
		int unsigned pick;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_WRITE;
		entry_index = '0;
		op_kind = KIND_CONTINUE;
		op_argument = '0;
		has_gradient = 1'b0;
		x_word = '0;
		y_word = '0;
		z_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty program: every step only reports finished
		rows.push_back(cfg_row(11'd0));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd0, 1'b1, STATUS_OK));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd0, KIND_CONTINUE, 24'd0, 1'b1,
			16'hffff, 16'h0000, 16'hffff));
		rows.push_back(cmd_row(FUNC_START, '0, '0, '0, 1'b0, '0, '0, '0));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd0, 1'b1, STATUS_OK));
		rows.push_back(cmd_row(FUNC_ABORT, '0, '0, '0, 1'b0, '0, '0, '0));
		// full length; error codes in a row, ended by a call out of range
		rows.push_back(cfg_row(11'd1024));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd1023, KIND_EXIT, 24'hffffff, 1'b1,
			16'hffff, 16'hffff, 16'hffff));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd1, KIND_UNKNOWN_TOP, 24'hffffff, 1'b0,
			'0, '0, '0));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd2, KIND_END_LOOP, 24'd0, 1'b1,
			16'h0000, 16'hffff, 16'h0000));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd3, KIND_RETURN, 24'd0, 1'b0, '0, '0, '0));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd4, KIND_CALL, 24'hffffff, 1'b0, '0, '0, '0));
		rows.push_back(cmd_row(FUNC_START, '0, '0, '0, 1'b0, '0, '0, '0));
		rows.push_back(step_row(1'b1, 16'hffff, 16'h0000, 16'hffff, 10'd0, 1'b0, STATUS_OK));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd1, 1'b0, STATUS_UNKNOWN));
		rows.push_back(step_row(1'b1, 16'h0000, 16'hffff, 16'h0000, 10'd2, 1'b0,
			STATUS_LOOP_EMPTY));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd3, 1'b0, STATUS_RET_EMPTY));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd4, 1'b1, STATUS_BAD_TARGET));
		rows.push_back(step_row(1'b0, '0, '0, '0, 10'd0, 1'b1, STATUS_OK));
		rows.push_back(cmd_row(FUNC_WRITE, 10'd0, KIND_EXIT, 24'd0, 1'b1,
			16'h0000, 16'hffff, 16'h0000));
		rows.push_back(cmd_row(FUNC_START, '0, '0, '0, 1'b0, '0, '0, '0));
		rows.push_back(step_row(1'b1, 16'h0000, 16'hffff, 16'h0000, 10'd0, 1'b1, STATUS_OK));
		rows.push_back(cmd_row(FUNC_ABORT, '0, '0, '0, 1'b0, '0, '0, '0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain_results();
				write_length(rows[i].cfg_val);
			end else begin
				typed_valid = rows[i].typed;
				typed_value = rows[i].want;
				send_item(rows[i].cmd);
				typed_valid = 1'b0;
			end
		end

		while (items_accepted < ITEM_TARGET) begin
			if (items_accepted > 2 * ITEM_TARGET / 3) idle_pct = 0;
			else if (items_accepted > ITEM_TARGET / 3) idle_pct = 69;
			else idle_pct = 33;
			pick = $urandom_range(99);
			if (pick < 40) run_scenario(SCEN_STRUCTURED);
			else if (pick < 85) run_scenario(SCEN_RANDOM);
			else run_scenario(SCEN_STACK_FILL);
		end

		drain_results();
		repeat (6) @(negedge clk);
		$display("covered %0d commands, %0d step reports checked (%0d with gradient, %0d finished)",
			items_accepted, reports_checked, gradient_reports, finished_reports);
		$display({"status seen: ok %0d, unknown %0d, overflow %0d, loop empty %0d,",
			" bad target %0d, return empty %0d"},
			status_seen[STATUS_OK], status_seen[STATUS_UNKNOWN], status_seen[STATUS_OVERFLOW],
			status_seen[STATUS_LOOP_EMPTY], status_seen[STATUS_BAD_TARGET],
			status_seen[STATUS_RET_EMPTY]);
		if (mismatches == 0 && step_reports_due.size() == 0) begin
			$display("event_program_sequencer test passed");
		end else begin
			$display("event_program_sequencer test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
